// File: rtl/core/lsg_pkg.sv
// Shared types and constants of the line-of-sight segment generator.
package lsg_pkg;

    localparam int LOC_W = 32;
    localparam int LEN_W = 48;
    localparam int IDX_W = 5;
    localparam int MU_W  = 32;
    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRACE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPAN  = 2'd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // One in Q2.30 and one squared in Q4.60.
    localparam logic [MU_W-1:0] MU_ONE = 32'h4000_0000;
    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

    typedef enum logic [1:0] {
        t_kind_span,
        t_kind_cart,
        t_kind_sph
    } t_kind;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] cell_idx;
    } t_seg;

endpackage

// File: rtl/core/lsg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/line_of_sight_segment_generator.sv
// Top level of the line-of-sight segment generator.
//
// The grid point table sits in one RAM with a registered read, and a
// sequencer walks it one point at a time. A load writes the table when it is
// accepted, and a span reads, measures and emits one segment per point. A
// cartesian trace runs each segment through the bit-serial divider (one
// quotient bit a cycle, 62 bits). A spherical trace first runs a setup (two
// 32-step square roots and four products on the shared multiplier) and then
// one chord root per segment; the tangent segment takes no root. Results leave
// through a one-deep pending stage and an output register, so the final result
// is flagged last; a stalled output holds the sequencer at its next emission.
module line_of_sight_segment_generator #(
    parameter int MAX_POINTS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [5:0]                  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lsg_pkg::CMD_W-1:0]   i_cmd,
    input  logic [lsg_pkg::IDX_W-1:0]   i_point_index,
    input  logic [lsg_pkg::IDX_W-1:0]   i_end_index,
    input  logic [lsg_pkg::LOC_W-1:0]   i_location,
    input  logic signed [lsg_pkg::MU_W-1:0] i_direction_cosine,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lsg_pkg::LEN_W-1:0]   o_segment_length,
    output logic [lsg_pkg::IDX_W-1:0]   o_cell_index,
    output logic                        o_wall_side,
    output logic                        o_empty_res,
    output logic                        o_path_error,
    output logic                        o_last
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_PRIME   = 5'd1;
    localparam logic [4:0] S_PRIME_D = 5'd2;
    localparam logic [4:0] S_READ    = 5'd3;
    localparam logic [4:0] S_DATA    = 5'd4;
    localparam logic [4:0] S_DIV     = 5'd5;
    localparam logic [4:0] S_DV_DONE = 5'd6;
    localparam logic [4:0] S_EMIT    = 5'd7;
    localparam logic [4:0] S_FINISH  = 5'd8;
    localparam logic [4:0] S_SP_MU   = 5'd9;
    localparam logic [4:0] S_SP_S    = 5'd10;
    localparam logic [4:0] S_SP_Y    = 5'd11;
    localparam logic [4:0] S_SP_Y2   = 5'd12;
    localparam logic [4:0] S_SP_YY   = 5'd13;
    localparam logic [4:0] S_SP_RR   = 5'd14;
    localparam logic [4:0] S_SP_XI   = 5'd15;
    localparam logic [4:0] S_CH_MUL  = 5'd16;
    localparam logic [4:0] S_CH_SQ   = 5'd17;
    localparam logic [4:0] S_SQRT    = 5'd18;
    localparam logic [4:0] S_SQ_DONE = 5'd19;

    localparam logic [1:0] PH_S  = 2'd0;
    localparam logic [1:0] PH_XI = 2'd1;
    localparam logic [1:0] PH_CH = 2'd2;

    function automatic logic [4:0] wrap_pt(input logic [4:0] p);
        logic [9:0] v;
        v = {5'b0, p};
        for (int j = 4; j >= 0; j--) begin
            if (v >= (10'(MAX_POINTS) << j)) begin
                v = v - (10'(MAX_POINTS) << j);
            end
        end
        return v[4:0];
    endfunction

    logic [4:0]  r_state;
    logic        r_mode;
    logic [5:0]  r_count;
    lsg_pkg::t_kind r_kind;
    logic        r_up;
    logic        r_wall;
    logic        r_err;
    logic        r_mu_pos;
    logic        r_case_a;
    logic        r_tan;
    logic        r_tan_hit;
    logic [1:0]  r_ph;
    logic [5:0]  r_cnt;
    logic [5:0]  r_p;
    logic [4:0]  r_idx;
    logic [4:0]  r_lo;
    logic [4:0]  r_cell;
    logic [30:0] r_amu;
    logic [31:0] r_prev;
    logic [31:0] r_cur;
    logic [31:0] r_y;
    logic [31:0] r_xi;
    logic [63:0] r_prod;
    logic [63:0] r_yy;
    logic [47:0] r_len;
    logic [63:0] r_sq_val;
    logic [34:0] r_sq_rem;
    logic [31:0] r_sq_root;
    logic [61:0] r_dv_num;
    logic [31:0] r_dv_rem;
    logic [61:0] r_q;
    logic        r_pend_v;
    lsg_pkg::t_seg r_pend;
    logic        r_out_valid;
    lsg_pkg::t_seg r_out;
    logic        r_o_wall;
    logic        r_o_empty;
    logic        r_o_err;
    logic        r_o_last;

    logic [5:0]  n_eff;
    logic [5:0]  idx_c;
    logic [5:0]  lo_c;
    logic        acc;
    logic        out_free;
    logic        out_load;
    logic        mu_bad;
    logic        mu_zero;
    logic [31:0] amu32;
    logic [4:0]  wr_pt;
    logic [AW-1:0] ram_raddr;
    logic [31:0] rdata;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [34:0] sq_sh;
    logic [34:0] sq_tr;
    logic        sq_ge;
    logic [31:0] dv_sh;
    logic        dv_ge;
    logic [31:0] walk_d;
    logic [63:0] ch_arg;
    logic [31:0] ch_len;

    // Effective point count, clamped into the supported range.
    always_comb begin
        if (r_count > 6'(MAX_POINTS)) begin
            n_eff = 6'(MAX_POINTS);
        end else if (r_count < 6'd2) begin
            n_eff = 6'd2;
        end else begin
            n_eff = r_count;
        end
    end

    assign idx_c = ({1'b0, i_point_index} >= n_eff) ? n_eff - 6'd1 : {1'b0, i_point_index};
    assign lo_c  = ({1'b0, i_end_index} >= n_eff) ? n_eff - 6'd1 : {1'b0, i_end_index};

    assign acc      = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = ((r_state == S_EMIT) && r_pend_v && out_free)
                   || ((r_state == S_FINISH) && out_free);

    assign mu_bad  = (i_direction_cosine > $signed(lsg_pkg::MU_ONE))
                  || (i_direction_cosine < -$signed(lsg_pkg::MU_ONE));
    assign mu_zero = (i_direction_cosine == '0);
    assign amu32   = i_direction_cosine[31] ? 32'(-i_direction_cosine)
                                            : 32'(i_direction_cosine);

    assign wr_pt = wrap_pt(i_point_index);

    always_comb begin
        case (r_state) inside
            S_PRIME, S_READ: ram_raddr = r_p[AW-1:0];
            S_SP_MU:         ram_raddr = r_idx[AW-1:0];
            default:         ram_raddr = '0;
        endcase
    end

    lsg_ram #(
        .WIDTH(lsg_pkg::LOC_W),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (acc && (i_cmd == lsg_pkg::CMD_LOAD)),
        .i_waddr(wr_pt[AW-1:0]),
        .i_wdata(i_location),
        .i_raddr(ram_raddr),
        .o_rdata(rdata)
    );

    // Shared multiplier; its product is registered every cycle.
    always_comb begin
        case (r_state)
            S_SP_MU: begin
                mul_a = {1'b0, r_amu};
                mul_b = {1'b0, r_amu};
            end
            S_SP_Y: begin
                mul_a = r_prev;
                mul_b = r_sq_root;
            end
            S_SP_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            S_SP_RR: begin
                mul_a = r_prev;
                mul_b = r_prev;
            end
            default: begin
                mul_a = r_cur;
                mul_b = r_cur;
            end
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // Square root, one result bit a cycle.
    assign sq_sh = {r_sq_rem[32:0], r_sq_val[63:62]};
    assign sq_tr = {1'b0, r_sq_root, 2'b01};
    assign sq_ge = (sq_sh >= sq_tr);

    // Restoring divide, one quotient bit a cycle.
    assign dv_sh = {r_dv_rem[30:0], r_dv_num[61]};
    assign dv_ge = (dv_sh >= {1'b0, r_amu});

    always_comb begin
        if (r_up) begin
            walk_d = (rdata > r_prev) ? rdata - r_prev : 32'd0;
        end else begin
            walk_d = (r_prev > rdata) ? r_prev - rdata : 32'd0;
        end
    end

    assign ch_arg = (r_prod > r_yy) ? r_prod - r_yy : 64'd0;

    always_comb begin
        if (r_up) begin
            ch_len = (r_sq_root > r_xi) ? r_sq_root - r_xi : 32'd0;
        end else begin
            ch_len = (r_xi > r_sq_root) ? r_xi - r_sq_root : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_count     <= 6'd32;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= mul_p;

            if (i_cfg_we) begin
                if (i_cfg_index == lsg_pkg::CFG_MODE) begin
                    r_mode <= i_cfg_data[0];
                end else begin
                    r_count <= i_cfg_data;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state) inside
                S_IDLE: begin
                    if (acc) begin
                        r_tan     <= 1'b0;
                        r_tan_hit <= 1'b0;
                        r_idx     <= idx_c[4:0];
                        r_p       <= idx_c;
                        case (i_cmd)
                            lsg_pkg::CMD_SPAN: begin
                                r_kind <= lsg_pkg::t_kind_span;
                                r_err  <= 1'b0;
                                r_up   <= 1'b0;
                                r_wall <= 1'b0;
                                r_lo   <= lo_c[4:0];
                                r_state <= (idx_c <= lo_c) ? S_FINISH : S_PRIME;
                            end
                            lsg_pkg::CMD_TRACE: begin
                                r_lo     <= 5'd0;
                                r_amu    <= amu32[30:0];
                                r_mu_pos <= !i_direction_cosine[31] && !mu_zero;
                                r_err    <= mu_bad || (!r_mode && mu_zero);
                                if (mu_bad || (!r_mode && mu_zero)) begin
                                    r_wall  <= 1'b0;
                                    r_state <= S_FINISH;
                                end else if (!r_mode) begin
                                    r_kind <= lsg_pkg::t_kind_cart;
                                    if (!i_direction_cosine[31]) begin
                                        r_up    <= 1'b0;
                                        r_wall  <= 1'b0;
                                        r_state <= (idx_c == 6'd0) ? S_FINISH : S_PRIME;
                                    end else begin
                                        r_up    <= 1'b1;
                                        r_wall  <= 1'b1;
                                        r_state <= (idx_c >= n_eff - 6'd1) ? S_FINISH
                                                                           : S_PRIME;
                                    end
                                end else begin
                                    r_kind  <= lsg_pkg::t_kind_sph;
                                    r_state <= S_SP_MU;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PRIME: begin
                    r_state <= S_PRIME_D;
                end
                S_PRIME_D: begin
                    r_prev  <= rdata;
                    r_p     <= r_up ? r_p + 6'd1 : r_p - 6'd1;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    r_cur  <= rdata;
                    r_cell <= r_up ? 5'(r_p - 6'd1) : r_p[4:0];
                    case (r_kind)
                        lsg_pkg::t_kind_span: begin
                            r_len   <= 48'(walk_d);
                            r_state <= S_EMIT;
                        end
                        lsg_pkg::t_kind_cart: begin
                            r_dv_num <= {walk_d, 30'b0};
                            r_dv_rem <= 32'd0;
                            r_q      <= 62'd0;
                            r_cnt    <= 6'd0;
                            r_state  <= S_DIV;
                        end
                        default: begin
                            // The inward walk stops at the tangent cell: the first
                            // point at or inside the impact radius, or point zero.
                            if (r_tan && !((r_p != 6'd0) && (rdata > r_y))) begin
                                r_tan_hit <= 1'b1;
                                r_len     <= 48'({r_xi, 1'b0});
                                r_state   <= S_EMIT;
                            end else begin
                                r_state <= S_CH_MUL;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    r_dv_rem <= dv_ge ? dv_sh - {1'b0, r_amu} : dv_sh;
                    r_q      <= {r_q[60:0], dv_ge};
                    r_dv_num <= {r_dv_num[60:0], 1'b0};
                    r_cnt    <= r_cnt + 6'd1;
                    if (r_cnt == 6'd61) begin
                        r_state <= S_DV_DONE;
                    end
                end
                S_DV_DONE: begin
                    r_len   <= (r_q[61:48] != '0) ? '1 : r_q[47:0];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_out       <= r_pend;
                            r_o_wall    <= r_wall;
                            r_o_empty   <= 1'b0;
                            r_o_err     <= 1'b0;
                            r_o_last    <= 1'b0;
                        end
                        r_pend_v        <= 1'b1;
                        r_pend.len      <= r_len;
                        r_pend.cell_idx <= r_cell;
                        r_prev          <= r_cur;
                        if (r_tan_hit) begin
                            // Past the tangent cell the ray turns outward.
                            r_tan_hit <= 1'b0;
                            r_tan     <= 1'b0;
                            r_up      <= 1'b1;
                            if (r_p + 6'd1 >= n_eff - 6'd1) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_p     <= r_p + 6'd2;
                                r_state <= S_READ;
                            end
                        end else if (r_up) begin
                            if (r_p == n_eff - 6'd1) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_p     <= r_p + 6'd1;
                                r_state <= S_READ;
                            end
                        end else begin
                            if (r_p == {1'b0, r_lo}) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_p     <= r_p - 6'd1;
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_o_wall    <= r_wall;
                        r_o_last    <= 1'b1;
                        if (r_pend_v) begin
                            r_out     <= r_pend;
                            r_o_empty <= 1'b0;
                            r_o_err   <= 1'b0;
                        end else begin
                            r_out.len      <= '0;
                            r_out.cell_idx <= '0;
                            r_o_empty      <= 1'b1;
                            r_o_err        <= r_err;
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_SP_MU: begin
                    r_state <= S_SP_S;
                end
                S_SP_S: begin
                    r_prev    <= rdata;
                    r_sq_val  <= lsg_pkg::ONE_Q60 - r_prod;
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= 6'd0;
                    r_ph      <= PH_S;
                    r_state   <= S_SQRT;
                end
                S_SP_Y: begin
                    r_state <= S_SP_Y2;
                end
                S_SP_Y2: begin
                    r_y     <= r_prod[61:30];
                    r_state <= S_SP_YY;
                end
                S_SP_YY: begin
                    r_case_a <= r_mu_pos && (r_y <= rdata);
                    r_state  <= S_SP_RR;
                end
                S_SP_RR: begin
                    r_yy    <= r_prod;
                    r_state <= S_SP_XI;
                end
                S_SP_XI, S_CH_SQ: begin
                    r_sq_val  <= ch_arg;
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= 6'd0;
                    r_ph      <= (r_state == S_SP_XI) ? PH_XI : PH_CH;
                    r_state   <= S_SQRT;
                end
                S_CH_MUL: begin
                    r_state <= S_CH_SQ;
                end
                S_SQRT: begin
                    r_sq_rem  <= sq_ge ? sq_sh - sq_tr : sq_sh;
                    r_sq_root <= {r_sq_root[30:0], sq_ge};
                    r_sq_val  <= {r_sq_val[61:0], 2'b00};
                    r_cnt     <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_state <= S_SQ_DONE;
                    end
                end
                S_SQ_DONE: begin
                    case (r_ph)
                        PH_S: begin
                            r_state <= S_SP_Y;
                        end
                        PH_XI: begin
                            r_xi <= r_sq_root;
                            if (r_case_a) begin
                                r_wall <= 1'b0;
                                r_up   <= 1'b0;
                                if (r_idx == 5'd0) begin
                                    r_state <= S_FINISH;
                                end else begin
                                    r_p     <= {1'b0, r_idx} - 6'd1;
                                    r_state <= S_READ;
                                end
                            end else if (r_mu_pos) begin
                                r_wall  <= 1'b1;
                                r_up    <= 1'b0;
                                r_tan   <= 1'b1;
                                r_p     <= {1'b0, r_idx} - 6'd1;
                                r_state <= S_READ;
                            end else begin
                                r_wall <= 1'b1;
                                r_up   <= 1'b1;
                                if ({1'b0, r_idx} >= n_eff - 6'd1) begin
                                    r_state <= S_FINISH;
                                end else begin
                                    r_p     <= {1'b0, r_idx} + 6'd1;
                                    r_state <= S_READ;
                                end
                            end
                        end
                        default: begin
                            r_len   <= 48'(ch_len);
                            r_xi    <= r_sq_root;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_segment_length = r_out.len;
    assign o_cell_index     = r_out.cell_idx;
    assign o_wall_side      = r_o_wall;
    assign o_empty_res      = r_o_empty;
    assign o_path_error     = r_o_err;
    assign o_last           = r_o_last;

endmodule

// File: rtl/core/lsg_checker.sv
// Port-level checks of the line-of-sight segment generator and their binding.
module lsg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic                        i_cfg_index,
    input logic [5:0]                  i_cfg_data,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [lsg_pkg::CMD_W-1:0]   i_cmd,
    input logic [lsg_pkg::IDX_W-1:0]   i_point_index,
    input logic [lsg_pkg::IDX_W-1:0]   i_end_index,
    input logic [lsg_pkg::LOC_W-1:0]   i_location,
    input logic signed [lsg_pkg::MU_W-1:0] i_direction_cosine,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [lsg_pkg::LEN_W-1:0]   o_segment_length,
    input logic [lsg_pkg::IDX_W-1:0]   o_cell_index,
    input logic                        o_wall_side,
    input logic                        o_empty_res,
    input logic                        o_path_error,
    input logic                        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_segment_length)
                               && $stable(o_cell_index))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_last)
        else $error("empty result is not the last of its run");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_path_error |-> o_empty_res && !o_wall_side
                                    && (o_segment_length == '0))
        else $error("error result carries data");

    a_trace_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == lsg_pkg::CMD_TRACE) |=> o_stall)
        else $error("trace transfer did not occupy the block");

endmodule

bind line_of_sight_segment_generator lsg_checker u_lsg_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the line-of-sight segment generator.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LEN_SAT = (64'd1 << lsg_pkg::LEN_W) - 64'd1;
    localparam int STALL_LIMIT = 20000;
    localparam logic [lsg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [lsg_pkg::LEN_W-1:0] len;
        logic [lsg_pkg::IDX_W-1:0] cell_idx;
        logic                      wall;
        logic                      empty;
        logic                      err;
        logic                      last;
    } t_seg_rec;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_index = lsg_pkg::CFG_MODE;
    logic [5:0]                      i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [lsg_pkg::CMD_W-1:0]       i_cmd = lsg_pkg::CMD_LOAD;
    logic [lsg_pkg::IDX_W-1:0]       i_point_index = '0;
    logic [lsg_pkg::IDX_W-1:0]       i_end_index = '0;
    logic [lsg_pkg::LOC_W-1:0]       i_location = '0;
    logic signed [lsg_pkg::MU_W-1:0] i_direction_cosine = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [lsg_pkg::LEN_W-1:0]       o_segment_length;
    logic [lsg_pkg::IDX_W-1:0]       o_cell_index;
    logic                            o_wall_side;
    logic                            o_empty_res;
    logic                            o_path_error;
    logic                            o_last;

    // Predictor state.
    logic [lsg_pkg::LOC_W-1:0] grid_loc [32];
    logic             geo_sph = 1'b0;
    logic [5:0]       pt_count = 6'd32;
    t_seg_rec         expected_segs [$];

    int  errors = 0;
    int  items_sent = 0;
    int  segs_seen = 0;
    int  quiet_cnt = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    line_of_sight_segment_generator dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res, bm;
        res = 0;
        bm = 64'd1 << 62;
        while (bm > v) bm = bm >> 2;
        while (bm != 0) begin
            if (v >= res + bm) begin
                v = v - (res + bm);
                res = (res >> 1) + bm;
            end else begin
                res = res >> 1;
            end
            bm = bm >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] chord(input logic [63:0] rr, input logic [63:0] y);
        return (rr * rr > y * y) ? isqrt(rr * rr - y * y) : 64'd0;
    endfunction

    function automatic logic [63:0] gap_of(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    task automatic add_seg(input logic [63:0] len, input int cell_no, input logic wall,
                           input logic empty, input logic err);
        t_seg_rec s;
        s.len = (len > LEN_SAT) ? LEN_SAT[lsg_pkg::LEN_W-1:0] : len[lsg_pkg::LEN_W-1:0];
        s.cell_idx = cell_no[lsg_pkg::IDX_W-1:0];
        s.wall = wall;
        s.empty = empty;
        s.err = err;
        s.last = 1'b0;
        expected_segs = {expected_segs, s};
    endtask

    task automatic predict_segments(input logic [lsg_pkg::CMD_W-1:0] cmd,
                                    input logic [4:0] pidx, input logic [4:0] eidx,
                                    input logic [31:0] loc, input logic signed [31:0] mu);
        int n, idx, lo, k, i, imin, start_out;
        logic wall;
        longint m;
        logic [63:0] amu, s, r, y, xi, xj, d;
        n = (pt_count > 32) ? 32 : (pt_count < 2 ? 2 : int'(pt_count));
        idx = (pidx >= n) ? n - 1 : int'(pidx);
        lo = (eidx >= n) ? n - 1 : int'(eidx);
        k = expected_segs.size();
        wall = 1'b0;
        m = longint'(mu);
        amu = (m < 0) ? -m : m;
        if (cmd == lsg_pkg::CMD_LOAD) begin
            grid_loc[pidx] = loc;
            return;
        end
        if (cmd == CMD_UNUSED) return;
        if (cmd == lsg_pkg::CMD_SPAN) begin
            for (i = idx - 1; i >= lo; i--)
                add_seg(gap_of(64'(grid_loc[i+1]), 64'(grid_loc[i])), i, 1'b0, 1'b0, 1'b0);
        end else if (m > 64'sd1073741824 || m < -64'sd1073741824 || (!geo_sph && m == 0)) begin
            add_seg(64'd0, 0, 1'b0, 1'b1, 1'b1);
        end else if (!geo_sph) begin
            wall = (m > 0) ? 1'b0 : 1'b1;
            if (m > 0) begin
                for (i = idx - 1; i >= 0; i--) begin
                    d = gap_of(64'(grid_loc[i+1]), 64'(grid_loc[i]));
                    add_seg((d << 30) / amu, i, wall, 1'b0, 1'b0);
                end
            end else begin
                for (i = idx; i <= n - 2; i++) begin
                    d = gap_of(64'(grid_loc[i+1]), 64'(grid_loc[i]));
                    add_seg((d << 30) / amu, i, wall, 1'b0, 1'b0);
                end
            end
        end else begin
            s = isqrt(lsg_pkg::ONE_Q60 - amu * amu);
            r = 64'(grid_loc[idx]);
            y = (r * s) >> 30;
            xi = chord(r, y);
            if (m > 0 && y <= 64'(grid_loc[0])) begin
                wall = 1'b0;
                for (i = idx - 1; i >= 0; i--) begin
                    xj = chord(64'(grid_loc[i]), y);
                    add_seg(gap_of(xi, xj), i, wall, 1'b0, 1'b0);
                    xi = xj;
                end
            end else begin
                wall = 1'b1;
                start_out = idx;
                if (m > 0) begin
                    // The ray misses the inner sphere: find the tangent cell.
                    imin = idx - 1;
                    while (imin > 0 && 64'(grid_loc[imin]) > y) imin--;
                    for (i = idx - 1; i > imin; i--) begin
                        xj = chord(64'(grid_loc[i]), y);
                        add_seg(gap_of(xi, xj), i, wall, 1'b0, 1'b0);
                        xi = xj;
                    end
                    add_seg(xi << 1, imin, wall, 1'b0, 1'b0);
                    start_out = imin + 1;
                end
                for (i = start_out; i < n - 1; i++) begin
                    xj = chord(64'(grid_loc[i+1]), y);
                    add_seg(gap_of(xj, xi), i, wall, 1'b0, 1'b0);
                    xi = xj;
                end
            end
        end
        if (expected_segs.size() == k) add_seg(64'd0, 0, wall, 1'b1, 1'b0);
        expected_segs[$].last = 1'b1;
    endtask

    // Sends one input transfer; valid stays high into the next call unless a gap is taken.
    task automatic send_item(input logic [lsg_pkg::CMD_W-1:0] cmd, input logic [4:0] pidx,
                             input logic [4:0] eidx, input logic [31:0] loc,
                             input logic signed [31:0] mu);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_point_index <= pidx;
        i_end_index <= eidx;
        i_location <= loc;
        i_direction_cosine <= mu;
        do @(posedge i_clk); while (o_stall);
        predict_segments(cmd, pidx, eidx, loc, mu);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_segs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [5:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == lsg_pkg::CFG_MODE) geo_sph = data[0];
        else pt_count = data;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic sph, input logic [5:0] count);
        drain();
        write_reg(lsg_pkg::CFG_MODE, {5'd0, sph});
        write_reg(lsg_pkg::CFG_COUNT, count);
    endtask

    task automatic load_sorted_grid(input int max_step);
        logic [31:0] v;
        v = $urandom_range(0, max_step);
        for (int i = 0; i < 32; i++) begin
            send_item(lsg_pkg::CMD_LOAD, i[4:0], 5'($urandom), v, $urandom);
            v = v + $urandom_range(1, max_step);
        end
    endtask

    function automatic logic signed [31:0] valid_mu();
        return $signed($urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
    endfunction

    task automatic test_load_grid();
        load_sorted_grid(32'h0001_0000);
    endtask

    task automatic test_span();
        set_mode(1'b0, 6'd32);
        send_item(lsg_pkg::CMD_SPAN, 5'd31, 5'd0, '0, '0);
        send_item(lsg_pkg::CMD_SPAN, 5'd4, 5'd9, '0, '0);
        send_item(lsg_pkg::CMD_SPAN, 5'd3, 5'd3, '0, '0);
        set_mode(1'b0, 6'd63);
        send_item(lsg_pkg::CMD_SPAN, 5'd31, 5'd29, '0, '0);
        send_item(CMD_UNUSED, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_cartesian();
        set_mode(1'b0, 6'd0);
        send_item(lsg_pkg::CMD_TRACE, 5'd31, 5'd0, '0, lsg_pkg::MU_ONE);
        set_mode(1'b0, 6'd8);
        send_item(lsg_pkg::CMD_TRACE, 5'd5, 5'd0, '0, -$signed(lsg_pkg::MU_ONE));
        send_item(lsg_pkg::CMD_TRACE, 5'd0, 5'd0, '0, 32'sd1 <<< 29);
        send_item(lsg_pkg::CMD_TRACE, 5'd31, 5'd0, '0, -32'sd12345);
        send_item(lsg_pkg::CMD_TRACE, 5'd7, 5'd0, '0, 32'sd1);
        // An unsorted table gives negative widths, which come out as zero.
        send_item(lsg_pkg::CMD_LOAD, 5'd3, 5'd0, 32'hFFFF_FFFF, '0);
        send_item(lsg_pkg::CMD_TRACE, 5'd7, 5'd0, '0, 32'sd7000);
        send_item(lsg_pkg::CMD_SPAN, 5'd7, 5'd0, '0, '0);
        send_item(lsg_pkg::CMD_LOAD, 5'd3, 5'd0, 32'h0000_0000, '0);
        send_item(lsg_pkg::CMD_TRACE, 5'd7, 5'd0, '0, lsg_pkg::MU_ONE);
    endtask

    task automatic test_errors();
        send_item(lsg_pkg::CMD_TRACE, 5'd4, 5'd0, '0, 32'sd0);
        send_item(lsg_pkg::CMD_TRACE, 5'd4, 5'd0, '0, lsg_pkg::MU_ONE + 1);
        send_item(lsg_pkg::CMD_TRACE, 5'd4, 5'd0, '0, 32'sh8000_0000);
        send_item(lsg_pkg::CMD_TRACE, 5'd4, 5'd0, '0, 32'sh7FFF_FFFF);
    endtask

    task automatic test_spherical();
        set_mode(1'b1, 6'd12);
        test_load_grid();
        send_item(lsg_pkg::CMD_TRACE, 5'd9, 5'd0, '0, lsg_pkg::MU_ONE);
        send_item(lsg_pkg::CMD_TRACE, 5'd9, 5'd0, '0, 32'sh1000_0000);
        send_item(lsg_pkg::CMD_TRACE, 5'd9, 5'd0, '0, -$signed(lsg_pkg::MU_ONE));
        send_item(lsg_pkg::CMD_TRACE, 5'd6, 5'd0, '0, 32'sd0);
        send_item(lsg_pkg::CMD_TRACE, 5'd11, 5'd0, '0, 32'sh3FFF_0000);
        send_item(lsg_pkg::CMD_TRACE, 5'd0, 5'd0, '0, lsg_pkg::MU_ONE);
        send_item(lsg_pkg::CMD_TRACE, 5'd4, 5'd0, '0, -(lsg_pkg::MU_ONE + 1));
    endtask

    task automatic test_random();
        logic [5:0] counts [6] = '{6'd2, 6'd32, 6'd5, 6'd17, 6'd45, 6'd1};
        int r;
        logic signed [31:0] mu;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) idle_on = 1'b0;
            set_mode(ph[0], counts[ph]);
            if (ph == 2) begin
                for (int i = 0; i < 32; i++)
                    send_item(lsg_pkg::CMD_LOAD, i[4:0], 5'($urandom), $urandom, $urandom);
            end else if (ph == 3) begin
                load_sorted_grid(32'h0100_0000);
            end
            for (int j = 0; j < 19; j++) begin
                r = $urandom_range(0, 99);
                mu = (r % 10 == 0) ? $signed($urandom) : valid_mu();
                if (r < 8)
                    send_item(lsg_pkg::CMD_LOAD, 5'($urandom), 5'($urandom), $urandom,
                              $urandom);
                else if (r < 10)
                    send_item(CMD_UNUSED, 5'($urandom), 5'($urandom), $urandom, $urandom);
                else if (r < 30)
                    send_item(lsg_pkg::CMD_SPAN, 5'($urandom), 5'($urandom), $urandom,
                              $urandom);
                else
                    send_item(lsg_pkg::CMD_TRACE, 5'($urandom), 5'($urandom), $urandom, mu);
            end
        end
        drain();
    endtask

    // Output stall in random bursts.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
    end

    // Compares every output transfer with the oldest expected segment.
    always @(posedge i_clk) begin
        t_seg_rec e;
        if (i_rst_n && o_valid && !i_stall) begin
            segs_seen++;
            if (expected_segs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, len %h cell %0d", $realtime,
                         o_segment_length, o_cell_index);
            end else begin
                e = expected_segs.pop_front();
                if (o_segment_length !== e.len)
                    $display("%0t: length expected %h actual %h", $realtime, e.len,
                             o_segment_length);
                if (o_cell_index !== e.cell_idx)
                    $display("%0t: cell expected %0d actual %0d", $realtime, e.cell_idx,
                             o_cell_index);
                if (o_wall_side !== e.wall)
                    $display("%0t: wall expected %b actual %b", $realtime, e.wall,
                             o_wall_side);
                if (o_empty_res !== e.empty)
                    $display("%0t: empty expected %b actual %b", $realtime, e.empty,
                             o_empty_res);
                if (o_path_error !== e.err)
                    $display("%0t: error flag expected %b actual %b", $realtime, e.err,
                             o_path_error);
                if (o_last !== e.last)
                    $display("%0t: last expected %b actual %b", $realtime, e.last, o_last);
                if (o_segment_length !== e.len || o_cell_index !== e.cell_idx ||
                    o_wall_side !== e.wall || o_empty_res !== e.empty ||
                    o_path_error !== e.err || o_last !== e.last)
                    errors++;
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_grid();
        test_span();
        test_cartesian();
        test_errors();
        test_spherical();
        test_random();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d items over span, cartesian and spherical traces,", items_sent);
        $display("with several grid sizes; %0d segments checked.", segs_seen);
        if (errors == 0 && expected_segs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
